// ----- rtl/dmrwh_pkg.sv -----
// Shared types, constants and modular arithmetic helpers for the double-modulus
// rolling window hash. Used by the front stage, the window pipeline and the top level; depends on nothing.
`default_nettype none

package dmrwh_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 20;
    localparam int LEN_W   = 11;
    localparam int HASH_W  = 30;
    localparam int RING_W  = 2 * HASH_W;

    // The element counter saturates at its all-ones value.
    localparam logic [LEN_W-1:0] SEEN_MAX = '1;

    // Lane 0 is the base-131 hash, lane 1 the base-31 hash.
    localparam logic [29:0] MOD_A = 30'd1000000007;
    localparam logic [29:0] MOD_B = 30'd1000000009;
    localparam logic [7:0]  BASE_A = 8'd131;
    localparam logic [7:0]  BASE_B = 8'd31;

    // 2^30 reduced by each modulus, used to fold high bits back into range.
    localparam logic [63:0] TWO30 = 64'd1 << 30;
    localparam logic [29:0] FOLD_A = 30'(TWO30 % 64'(MOD_A));
    localparam logic [29:0] FOLD_B = 30'(TWO30 % 64'(MOD_B));

    // Barrett reciprocals floor(2^60 / m) for the window product reduction.
    localparam logic [63:0] TWO60 = 64'd1 << 60;
    localparam logic [30:0] MU_A = 31'(TWO60 / 64'(MOD_A));
    localparam logic [30:0] MU_B = 31'(TWO60 / 64'(MOD_B));

    localparam logic [1:0][29:0] LANE_MOD  = {MOD_B, MOD_A};
    localparam logic [1:0][7:0]  LANE_BASE = {BASE_B, BASE_A};
    localparam logic [1:0][29:0] LANE_FOLD = {FOLD_B, FOLD_A};
    localparam logic [1:0][30:0] LANE_MU   = {MU_B, MU_A};

    // Everything the front stage hands to the window pipeline for one beat.
    typedef struct packed {
        logic              full;      // a complete window ends at this element
        logic              need_old;  // the prefix before the window comes from the ring
        logic [1:0][29:0]  prefix;    // prefix hash including this element
        logic [1:0][29:0]  power;     // base^L for each lane
    } s1_t;

    // Computes (p * base + addend) mod m, with p < m and d = 2^30 mod m.
    // Two folds of the bits above 2^30 leave a value below 2m.
    function automatic logic [29:0] mul_add_mod(
        input logic [29:0] p,
        input logic [7:0]  base,
        input logic [20:0] addend,
        input logic [29:0] m,
        input logic [29:0] d
    );
        logic [37:0] x;
        logic [33:0] y;
        logic [30:0] z;
        x = 38'(p) * 38'(base) + 38'(addend);
        y = 34'(x[37:30]) * 34'(d) + 34'(x[29:0]);
        z = 31'(y[33:30]) * 31'(d) + 31'(y[29:0]);
        if (z >= 31'(m))
        begin
            z = z - 31'(m);
        end
        return z[29:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dmrwh_ram.sv -----
// Generic single-write, single-read RAM with a registered, read-first output.
// Stands alone; holds the prefix ring of the rolling hash.
`default_nettype none

module dmrwh_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/dmrwh_prefix.sv -----
// Front stage: window length register, prefix and power recurrences, element
// counter and ring addressing. Depends on dmrwh_pkg.
`default_nettype none

module dmrwh_prefix #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [10:0]                           cfg_wr_data,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic [19:0]                           value,
    input  logic                                  start_req,
    input  logic                                  win_ready,
    output logic                                  s1_valid,
    output dmrwh_pkg::s1_t                        s1,
    output logic                                  ram_wr_en,
    output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] ram_wr_addr,
    output logic [59:0]                           ram_wr_data,
    output logic                                  ram_rd_en,
    output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] ram_rd_addr
);
    import dmrwh_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = ((AW + 1 > LEN_W) ? AW + 1 : LEN_W) + 1;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [1:0][29:0]  prefix_reg;
    logic [1:0][29:0]  prefix_next;
    logic [1:0][29:0]  power_reg;
    logic [1:0][29:0]  power_next;
    logic [LEN_W-1:0]  seen_reg;
    logic [LEN_W-1:0]  seen_next;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     pos_next;
    logic              s1_valid_reg;
    s1_t               s1_reg;
    s1_t               s1_next;

    logic              s1_ready;
    logic              accept;
    logic [20:0]       addend;
    logic [1:0][29:0]  prefix_base;
    logic [1:0][29:0]  power_base;
    logic [LEN_W-1:0]  seen_base;
    logic [AW-1:0]     pos_base;
    logic [SW-1:0]     slot_diff;
    logic [AW-1:0]     slot;

    assign s1_ready   = !s1_valid_reg || win_ready;
    assign item_stall = !s1_ready;
    assign accept     = item_valid && s1_ready;

    // Clamp a written window length into 1..MAX_WINDOW.
    always_comb
    begin
        len_next = cfg_wr_data;
        if (cfg_wr_data == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (SW'(cfg_wr_data) > SW'(MAX_WINDOW))
        begin
            len_next = LEN_W'(MAX_WINDOW);
        end
    end

    // A start request begins from the cleared state before this element.
    always_comb
    begin
        addend    = {1'b0, value} + 21'd1;
        seen_base = start_req ? '0 : seen_reg;
        pos_base  = start_req ? '0 : pos_reg;
        for (int l = 0; l < 2; l++)
        begin
            prefix_base[l] = start_req ? 30'd0 : prefix_reg[l];
            power_base[l]  = start_req ? 30'd1 : power_reg[l];
        end
    end

    // Counter, ring position and the slot that holds the prefix before the window.
    always_comb
    begin
        seen_next = (seen_base == SEEN_MAX) ? seen_base : seen_base + LEN_W'(1);
        pos_next  = (pos_base == AW'(MAX_WINDOW - 1)) ? '0 : pos_base + AW'(1);
        slot_diff = SW'(pos_next) - SW'(len_reg);
        if (SW'(pos_next) < SW'(len_reg))
        begin
            slot_diff = slot_diff + SW'(MAX_WINDOW);
        end
        slot = slot_diff[AW-1:0];
    end

    // Prefix and power recurrences, one constant multiply and fold per lane.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            prefix_next[l] = mul_add_mod(prefix_base[l], LANE_BASE[l], addend,
                                         LANE_MOD[l], LANE_FOLD[l]);
            power_next[l]  = power_base[l];
            if (seen_next <= len_reg)
            begin
                power_next[l] = mul_add_mod(power_base[l], LANE_BASE[l], 21'd0,
                                            LANE_MOD[l], LANE_FOLD[l]);
            end
        end
        s1_next.full     = (seen_next >= len_reg);
        s1_next.need_old = (seen_next > len_reg);
        s1_next.prefix   = prefix_next;
        s1_next.power    = power_next;
    end

    // Ring write of the new prefix and read of the older one in the same cycle.
    assign ram_wr_en   = accept;
    assign ram_wr_addr = pos_next;
    assign ram_wr_data = {prefix_next[1], prefix_next[0]};
    assign ram_rd_en   = accept;
    assign ram_rd_addr = slot;

    // Sequence state; a length write restarts the sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            prefix_reg   <= '0;
            power_reg    <= {30'd1, 30'd1};
            seen_reg     <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg    <= len_next;
                prefix_reg <= '0;
                power_reg  <= {30'd1, 30'd1};
                seen_reg   <= '0;
                pos_reg    <= '0;
            end
            else if (accept)
            begin
                prefix_reg <= prefix_next;
                power_reg  <= power_next;
                seen_reg   <= seen_next;
                pos_reg    <= pos_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    // Stage payload, aligned with the registered ring read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    // The running prefixes and powers always stay reduced.
    a_state_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_reg[0] < MOD_A && prefix_reg[1] < MOD_B &&
        power_reg[0] < MOD_A && power_reg[1] < MOD_B)
        else $error("prefix or power state out of modular range");

    // An accepted beat is always held in the stage register afterwards.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost before the window pipeline");

    // A start request leaves exactly one element counted.
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_req && !cfg_wr_en |=> seen_reg == LEN_W'(1))
        else $error("start request did not restart the element count");

endmodule

`default_nettype wire

// ----- rtl/dmrwh_window.sv -----
// Window pipeline: subtracts the scaled older prefix from the current one in
// both moduli, with Barrett reduction of the product. Depends on dmrwh_pkg.
`default_nettype none

module dmrwh_window (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s1_valid,
    input  dmrwh_pkg::s1_t  s1,
    input  logic [59:0]     ring_rd,
    output logic            s1_ready,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [29:0]     hash_a,
    output logic [29:0]     hash_b,
    output logic            window_valid
);
    import dmrwh_pkg::*;

    // Stages: product, quotient estimate, quotient times modulus, remainder, result.
    localparam int NS = 5;

    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     vld_next;
    logic [NS:0]       rdy;

    logic [1:0][59:0]  prod_reg;
    logic [1:0][59:0]  prod_next;
    logic [1:0][29:0]  pfx2_reg;
    logic              full2_reg;

    logic [1:0][30:0]  quo_reg;
    logic [1:0][30:0]  quo_next;
    logic [1:0][31:0]  lo3_reg;
    logic [1:0][29:0]  pfx3_reg;
    logic              full3_reg;

    logic [1:0][31:0]  qm_reg;
    logic [1:0][31:0]  qm_next;
    logic [1:0][31:0]  lo4_reg;
    logic [1:0][29:0]  pfx4_reg;
    logic              full4_reg;

    logic [1:0][29:0]  rem_reg;
    logic [1:0][29:0]  rem_next;
    logic [1:0][29:0]  pfx5_reg;
    logic              full5_reg;

    logic [1:0][29:0]  hash_reg;
    logic [1:0][29:0]  hash_next;
    logic              wvalid_reg;

    logic [1:0][29:0]  old_pfx;
    logic [1:0][61:0]  recip_prod;
    logic [1:0][60:0]  qm_full;
    logic [1:0][31:0]  diff;
    logic [1:0][30:0]  sub;

    // Each stage may load when it is empty or the one after it moves.
    always_comb
    begin
        rdy[NS] = !result_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next = {vld_reg[NS-2:0], s1_valid};
    end

    assign s1_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Datapath for both lanes.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            // Older prefix times base^L; zero when the window starts at the sequence head.
            old_pfx[l]   = s1.need_old ? ring_rd[30*l +: 30] : 30'd0;
            prod_next[l] = 60'(old_pfx[l]) * 60'(s1.power[l]);

            // Quotient estimate, at most two below the true quotient.
            recip_prod[l] = 62'(prod_reg[l][59:29]) * 62'(LANE_MU[l]);
            quo_next[l]   = recip_prod[l][61:31];

            // Only the low 32 bits matter: the remainder stays below 3m.
            qm_full[l] = 61'(quo_reg[l]) * 61'(LANE_MOD[l]);
            qm_next[l] = qm_full[l][31:0];

            // Remainder with up to two corrections.
            diff[l] = lo4_reg[l] - qm_reg[l];
            if (diff[l] >= 32'(LANE_MOD[l]))
            begin
                diff[l] = diff[l] - 32'(LANE_MOD[l]);
            end
            if (diff[l] >= 32'(LANE_MOD[l]))
            begin
                diff[l] = diff[l] - 32'(LANE_MOD[l]);
            end
            rem_next[l] = diff[l][29:0];

            // Window hash is the current prefix minus the scaled older one.
            sub[l] = 31'(pfx5_reg[l]) + 31'(LANE_MOD[l]) - 31'(rem_reg[l]);
            if (sub[l] >= 31'(LANE_MOD[l]))
            begin
                sub[l] = sub[l] - 31'(LANE_MOD[l]);
            end
            hash_next[l] = full5_reg ? sub[l][29:0] : 30'd0;
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            prod_reg  <= prod_next;
            pfx2_reg  <= s1.prefix;
            full2_reg <= s1.full;
        end
        if (rdy[1])
        begin
            quo_reg   <= quo_next;
            lo3_reg   <= {prod_reg[1][31:0], prod_reg[0][31:0]};
            pfx3_reg  <= pfx2_reg;
            full3_reg <= full2_reg;
        end
        if (rdy[2])
        begin
            qm_reg    <= qm_next;
            lo4_reg   <= lo3_reg;
            pfx4_reg  <= pfx3_reg;
            full4_reg <= full3_reg;
        end
        if (rdy[3])
        begin
            rem_reg   <= rem_next;
            pfx5_reg  <= pfx4_reg;
            full5_reg <= full4_reg;
        end
        if (rdy[4])
        begin
            hash_reg   <= hash_next;
            wvalid_reg <= full5_reg;
        end
    end

    assign result_valid = vld_reg[NS-1];
    assign hash_a       = hash_reg[0];
    assign hash_b       = hash_reg[1];
    assign window_valid = wvalid_reg;

    // The Barrett correction leaves a fully reduced remainder.
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> rem_reg[0] < MOD_A && rem_reg[1] < MOD_B)
        else $error("product remainder not reduced");

    // A result without a full window carries zero hashes.
    a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !window_valid |-> hash_a == 30'd0 && hash_b == 30'd0)
        else $error("hash bits set on a partial window");

    // Delivered hashes are reduced.
    a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hash_a < MOD_A && hash_b < MOD_B)
        else $error("window hash out of modular range");

endmodule

`default_nettype wire

// ----- rtl/double_mod_rolling_window_hash.sv -----
// Double-modulus rolling window hash, top level. Instantiates the front stage,
// the prefix ring RAM and the window pipeline; depends on dmrwh_pkg.
//
// One element is taken per clock cycle while item_stall is low, and each
// yields exactly one result beat through the front stage and the pipeline. The
// cycle is set by the prefix recurrence: a multiply by the small base and a
// two-step fold reduction per modulus, which must finish before the next
// element. The window product and its Barrett reduction run in a five-stage
// pipeline behind it, and the ring of MAX_WINDOW earlier prefixes is one RAM
// read and written in the cycle an element is accepted. Writing the window
// length (clamped into 1..MAX_WINDOW) restarts the sequence, as start_req does;
// write it only while no beats are in flight. The ring needs no clearing after
// reset, so elements are accepted from the first cycle.
`default_nettype none

module double_mod_rolling_window_hash #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [19:0] value,
    input  logic        start_req,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [29:0] hash_a,
    output logic [29:0] hash_b,
    output logic        window_valid
);
    import dmrwh_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic              win_ready;
    logic              s1_valid;
    s1_t               s1;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [RING_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [RING_W-1:0] ram_rd_data;

    // Recurrences, counters and ring addressing.
    dmrwh_prefix #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_prefix (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .value       (value),
        .start_req   (start_req),
        .win_ready   (win_ready),
        .s1_valid    (s1_valid),
        .s1          (s1),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    // Ring of earlier prefix pairs.
    dmrwh_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Window hash pipeline and result register.
    dmrwh_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1           (s1),
        .ring_rd      (ram_rd_data),
        .s1_ready     (win_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash_a       (hash_a),
        .hash_b       (hash_b),
        .window_valid (window_valid)
    );

endmodule

`default_nettype wire

// ----- dv/window_hash_checker.sv -----
// Checker for the double-modulus rolling window hash: watches the config port and both
// beat channels, predicts each result beat and compares it field by field.
// Stands alone; needs only the signals of the block's ports.
module window_hash_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [19:0] value,
    input  logic        start_req,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [29:0] hash_a,
    input  logic [29:0] hash_b,
    input  logic        window_valid,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] MOD_A      = 64'd1000000007;
    localparam bit [63:0] MOD_B      = 64'd1000000009;
    localparam bit [63:0] MULT_A     = 64'd131;
    localparam bit [63:0] MULT_B     = 64'd31;
    localparam int        RING_DEPTH = 1024;
    localparam int        SEEN_LIMIT = 2047;

    typedef struct packed {
        bit [29:0] hash_a;
        bit [29:0] hash_b;
        bit        window_valid;
    } window_hash_t;

    // Predicted results, oldest first.
    window_hash_t expected_hashes[$];

    // Predicted sequence state.
    bit [63:0] pfx_a;
    bit [63:0] pfx_b;
    bit [63:0] pow_a;
    bit [63:0] pow_b;
    int        seen;
    int        ring_wr;
    bit [10:0] window_len;
    bit [59:0] prefix_hist [RING_DEPTH];

    function automatic void restart_sequence();
        pfx_a   = 64'd0;
        pfx_b   = 64'd0;
        pow_a   = 64'd1;
        pow_b   = 64'd1;
        seen    = 0;
        ring_wr = 0;
    endfunction

    // Takes one element into the prefixes and returns the hash pair of the window
    // that ends at it.
    function automatic window_hash_t advance_window(input bit [19:0] elem,
                                                    input bit restart_seq);
        bit [63:0]    term;
        bit [63:0]    old_a;
        bit [63:0]    old_b;
        int           span;
        int           slot;
        window_hash_t res;
        term = 64'(elem) + 64'd1;
        if (window_len == 11'd0)
        begin
            span = 1;
        end
        else if (int'(window_len) > RING_DEPTH)
        begin
            span = RING_DEPTH;
        end
        else
        begin
            span = int'(window_len);
        end
        if (restart_seq)
        begin
            restart_sequence();
        end
        pfx_a   = (pfx_a * MULT_A + term) % MOD_A;
        pfx_b   = (pfx_b * MULT_B + term) % MOD_B;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (seen < SEEN_LIMIT)
        begin
            seen++;
        end
        if (seen <= span)
        begin
            pow_a = (pow_a * MULT_A) % MOD_A;
            pow_b = (pow_b * MULT_B) % MOD_B;
        end
        res = '0;
        if (seen >= span)
        begin
            old_a = 64'd0;
            old_b = 64'd0;
            // Past the first full window the prefix before the window comes from
            // the history ring; the slot is read before this element overwrites it.
            if (seen > span)
            begin
                slot  = (ring_wr + RING_DEPTH - span) % RING_DEPTH;
                old_a = 64'(prefix_hist[slot][29:0]) % MOD_A;
                old_b = 64'(prefix_hist[slot][59:30]) % MOD_B;
            end
            res.hash_a       = 30'((pfx_a + MOD_A - (old_a * pow_a) % MOD_A) % MOD_A);
            res.hash_b       = 30'((pfx_b + MOD_B - (old_b * pow_b) % MOD_B) % MOD_B);
            res.window_valid = 1'b1;
        end
        prefix_hist[ring_wr] = {pfx_b[29:0], pfx_a[29:0]};
        return res;
    endfunction

    function automatic void check_field(input string name, input bit [29:0] want,
                                        input logic [29:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Results are compared before new elements are predicted; as each element is registered
    // before its result, a beat accepted now can never belong to an element accepted now.
    always @(posedge clk or negedge rst_n)
    begin
        window_hash_t want;
        if (!rst_n)
        begin
            expected_hashes.delete();
            window_len = 11'd1;
            restart_sequence();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, hash_a %0d hash_b %0d",
                             $time, hash_a, hash_b);
                    fail_count++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    check_field("hash_a", want.hash_a, hash_a);
                    check_field("hash_b", want.hash_b, hash_b);
                    check_field("window_valid", 30'(want.window_valid), 30'(window_valid));
                end
            end
            // A length write restarts the sequence.
            if (cfg_wr_en)
            begin
                window_len = cfg_wr_data;
                restart_sequence();
            end
            if (item_valid && !item_stall)
            begin
                expected_hashes.push_back(advance_window(value, start_req));
            end
            pending <= expected_hashes.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Top of the rolling window hash testbench: clock, reset, stimulus and verdict.
// Instantiates double_mod_rolling_window_hash and window_hash_checker beside it.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_GAP   = 12;
    localparam int STALL_LIMIT = 3000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [10:0] cfg_wr_data  = '0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [19:0] value        = '0;
    logic        start_req    = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [29:0] hash_a;
    logic [29:0] hash_b;
    logic        window_valid;

    int fail_count;
    int pending_hashes;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served;
    int hold_left;
    int idle_cycles    = 0;

    always #5 clk = ~clk;

    double_mod_rolling_window_hash u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .start_req    (start_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash_a       (hash_a),
        .hash_b       (hash_b),
        .window_valid (window_valid)
    );

    window_hash_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .start_req    (start_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash_a       (hash_a),
        .hash_b       (hash_b),
        .window_valid (window_valid),
        .fail_count   (fail_count),
        .pending      (pending_hashes)
    );

    // Result side: a long hold-off when one is requested, random stalls otherwise.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
            holds_served = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (item_valid && !item_stall)
            || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one element beat, idling each cycle in front of it with the set odds,
    // and waits until it is taken.
    task automatic send_beat(input logic [19:0] elem, input logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= elem;
        start_req  <= first;
        do @(posedge clk); while (item_stall);
    endtask

    // Stops offering beats until every predicted result has come out.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_hashes != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [10:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [19:0] random_elem();
        case ($urandom_range(9))
            0:       return 20'd0;
            1:       return 20'hFFFFF;
            default: return 20'($urandom());
        endcase
    endfunction

    // Mostly short windows so that full windows are common; now and then the clamped
    // and oversized lengths.
    function automatic logic [10:0] pick_window_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            return 11'($urandom_range(1, 12));
        end
        else if (pick < 70)
        begin
            return 11'($urandom_range(13, 64));
        end
        else if (pick < 78)
        begin
            return 11'd0;
        end
        else if (pick < 86)
        begin
            return 11'd2047;
        end
        else if (pick < 92)
        begin
            return 11'd1024;
        end
        return 11'($urandom_range(65, 2047));
    endfunction

    // Segments of well-formed sequences under one window length each; some sequences
    // lack their start mark and a few carry a stray one.
    task automatic run_random_phase(input int n_items, input bit with_hold);
        int         sent;
        int         seg;
        int         seg_left;
        int         seq_len;
        int         span;
        logic [10:0] len_reg;
        logic        first;
        sent = 0;
        seg  = 0;
        while (sent < n_items)
        begin
            wait_drained();
            len_reg = pick_window_length();
            write_window_length(len_reg);
            span = (len_reg == 11'd0) ? 1 : ((len_reg > 11'd1024) ? 1024 : int'(len_reg));
            if (with_hold && seg == 0)
            begin
                hold_requests++;
            end
            seg_left = $urandom_range(40, 120);
            while (seg_left > 0)
            begin
                seq_len = $urandom_range(1, 2 * span + 4);
                if (seq_len > seg_left)
                begin
                    seq_len = seg_left;
                end
                for (int i = 0; i < seq_len; i++)
                begin
                    if (i == 0)
                    begin
                        first = ($urandom_range(9) != 0);
                    end
                    else
                    begin
                        first = ($urandom_range(39) == 0);
                    end
                    send_beat(random_elem(), first);
                end
                seg_left -= seq_len;
                sent += seq_len;
            end
            seg++;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 13;
        recv_stall_pct = 52;

        // Reset length of one, extreme element values.
        send_beat(20'd0, 1'b1);
        send_beat(20'hFFFFF, 1'b0);
        send_beat(20'd5, 1'b0);

        // Window of three: not yet full, exactly full, then from the ring, then a
        // restart in the middle of the sequence.
        wait_drained();
        write_window_length(11'd3);
        send_beat(20'hFFFFF, 1'b1);
        send_beat(20'd0, 1'b0);
        send_beat(20'hAAAAA, 1'b0);
        send_beat(20'h55555, 1'b0);
        send_beat(20'd1, 1'b0);
        send_beat(20'd7, 1'b1);
        send_beat(20'd8, 1'b0);
        send_beat(20'd9, 1'b0);
        send_beat(20'd10, 1'b0);

        // Length zero clamps up to one.
        wait_drained();
        write_window_length(11'd0);
        send_beat(20'd3, 1'b1);
        send_beat(20'd4, 1'b0);

        // Oversized length clamps down to the ring depth.
        wait_drained();
        write_window_length(11'd2047);
        send_beat(20'd0, 1'b1);
        send_beat(20'hFFFFF, 1'b0);
        send_beat(20'd1, 1'b0);

        // The length write alone restarts the sequence.
        wait_drained();
        write_window_length(11'd2);
        repeat (3) send_beat(20'hFFFFF, 1'b0);

        run_random_phase(80, 1'b1);

        send_idle_pct  = 52;
        recv_stall_pct = 13;
        run_random_phase(80, 1'b1);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase(80, 1'b0);

        // One long sequence at the largest window: ring wrap-around, and the older
        // prefix read from the slot that the same element overwrites.
        wait_drained();
        write_window_length(11'd1024);
        for (int i = 0; i < 1040; i++)
        begin
            send_beat(random_elem(), i == 0);
        end

        wait_drained();
        if (fail_count == 0 && pending_hashes == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dmrwh_pkg.sv
rtl/dmrwh_ram.sv
rtl/dmrwh_prefix.sv
rtl/dmrwh_window.sv
rtl/double_mod_rolling_window_hash.sv
dv/window_hash_checker.sv
dv/tb_top.sv
